// File: design/zone_display_list_builder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the zoned display list builder
// Expect signals named clk and rst in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ZONE_DISPLAY_LIST_BUILDER_MACROS_SVH
`define ZONE_DISPLAY_LIST_BUILDER_MACROS_SVH

// Same-cycle implication
`define ZDLB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ZDLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/zdlb_pkg.sv
// ---------------------------------------------------------------------------
// zdlb_pkg
// Shared types and codes of the zoned display list builder.
// ---------------------------------------------------------------------------
package zdlb_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int STEP_W      = 4;
  localparam int SUM_W       = 9;
  localparam logic [7:0] INDIRECT_MODE = 8'h60;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_SWAP   = 2'd1,
    FUNC_SPRITE = 2'd2,
    FUNC_STRING = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    EMIT_CLEAR,
    EMIT_A,
    EMIT_B,
    EMIT_NONE
  } emit_t;

  typedef struct packed {
    logic              load;
    logic              calc_div;
    logic              calc_zone;
    logic              clear_half;
    logic              toggle_half;
    logic              rd_en;
    logic              rd_b;
    logic              cap_a;
    logic              cap_b;
    logic              emit;
    emit_t             kind;
    logic [STEP_W-1:0] step;
    logic              last;
    logic              commit;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  split;
    logic  ok_a;
    logic  ok_b;
    logic  out_free;
  } dp_stat_t;

endpackage

// File: design/zdlb_ram.sv
// ---------------------------------------------------------------------------
// zdlb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module zdlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/zdlb_dp.sv
// ---------------------------------------------------------------------------
// zdlb_dp
// Datapath: request registers, zone arithmetic, fill length store, output
// register.
// ---------------------------------------------------------------------------
module zdlb_dp #(
  parameter int NUM_ZONES  = 32,
  parameter int ZONE_BYTES = 32,
  parameter int ZONE_LINES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  zdlb_pkg::dp_cmd_t cmd,
  output zdlb_pkg::dp_stat_t stat,
  input  logic [1:0]        func,
  input  logic [15:0]       gfx_address,
  input  logic [7:0]        x_position,
  input  logic [7:0]        y_position,
  input  logic [7:0]        width_palette,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              write_valid,
  output logic [4:0]        write_zone,
  output logic [4:0]        write_offset,
  output logic [7:0]        write_byte,
  output logic              front_half,
  output logic              overflow,
  output logic              last
);

  localparam int ZW    = $clog2(NUM_ZONES);
  localparam int FW    = $clog2(ZONE_BYTES);
  localparam int HALF  = NUM_ZONES / 2;
  localparam int SUM_W = zdlb_pkg::SUM_W;

  // Reciprocals exact for every dividend below 2**SUM_W and divisor up to 64
  localparam int DIV_SHIFT = 16;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;
  localparam int Y_RECIP   = ((1 << DIV_SHIFT) + ZONE_LINES - 1) / ZONE_LINES;
  localparam int Z_RECIP   = ((1 << DIV_SHIFT) + NUM_ZONES - 1) / NUM_ZONES;

  zdlb_pkg::func_t  func_q;
  logic [15:0]      addr_q;
  logic [7:0]       x_q;
  logic [7:0]       y_q;
  logic [7:0]       wpal_q;
  logic [SUM_W-1:0] quo_q;
  logic [7:0]       rem_q;
  logic [ZW-1:0]    zone_a;
  logic [ZW-1:0]    zone_b;
  logic [FW-1:0]    fill_a;
  logic [FW-1:0]    fill_b;
  logic [NUM_ZONES-1:0] vld;
  logic             build_half;

  logic [ZW-1:0]     base;
  logic [PROD_W-1:0] y_prod;
  logic [SUM_W-1:0]  y_quo;
  logic [SUM_W-1:0]  y_rem;
  logic [SUM_W-1:0]  z_sum;
  logic [PROD_W-1:0] z_prod;
  logic [SUM_W-1:0]  z_quo;
  logic [SUM_W-1:0]  z_rem;
  logic [ZW-1:0]     zone_mod;
  logic [2:0]        len;
  logic              split;
  logic              ok_a;
  logic              ok_b;
  logic              ovf;

  logic             wr_en;
  logic [ZW-1:0]    wr_addr;
  logic [FW-1:0]    wr_data;
  logic [ZW-1:0]    rd_addr;
  logic [FW-1:0]    rd_data;

  logic [ZW-1:0]    sel_zone;
  logic [FW-1:0]    sel_fill;
  logic [7:0]       hi_a;
  logic [7:0]       hi_sel;
  logic [2:0]       idx;
  logic [7:0]       entry_byte;
  logic [SUM_W-1:0] off_ext;
  logic [SUM_W-1:0] zone_ext;

  assign base     = build_half ? ZW'(HALF) : '0;

  // Line to zone by reciprocal multiplication, remainder by back-multiply
  assign y_prod   = PROD_W'(y_q) * PROD_W'(Y_RECIP);
  assign y_quo    = y_prod[PROD_W-1:DIV_SHIFT];
  assign y_rem    = SUM_W'(y_q) - y_quo * SUM_W'(ZONE_LINES);

  // Wrap the zone round the list count the same way
  assign z_sum    = quo_q + SUM_W'(base);
  assign z_prod   = PROD_W'(z_sum) * PROD_W'(Z_RECIP);
  assign z_quo    = z_prod[PROD_W-1:DIV_SHIFT];
  assign z_rem    = z_sum - z_quo * SUM_W'(NUM_ZONES);
  assign zone_mod = z_rem[ZW-1:0];

  assign len   = (func_q == zdlb_pkg::FUNC_STRING) ? 3'd5 : 3'd4;
  assign split = (func_q == zdlb_pkg::FUNC_SPRITE) && (rem_q != 8'd0);
  assign ok_a  = (SUM_W'(fill_a) + SUM_W'(len) + SUM_W'(1)) < SUM_W'(ZONE_BYTES);
  assign ok_b  = (SUM_W'(fill_b) + SUM_W'(len) + SUM_W'(1)) < SUM_W'(ZONE_BYTES);
  assign ovf   = ((func_q == zdlb_pkg::FUNC_SPRITE) || (func_q == zdlb_pkg::FUNC_STRING))
                 && (!ok_a || (split && !ok_b));

  assign stat.func     = func_q;
  assign stat.split    = split;
  assign stat.ok_a     = ok_a;
  assign stat.ok_b     = ok_b;
  assign stat.out_free = !out_valid || out_ready;

  // Fill length store; entries not yet written since a clear read as zero
  assign wr_en   = cmd.emit && cmd.commit;
  assign wr_addr = (cmd.kind == zdlb_pkg::EMIT_B) ? zone_b : zone_a;
  assign wr_data = ((cmd.kind == zdlb_pkg::EMIT_B) ? fill_b : fill_a) + FW'(len);
  assign rd_addr = cmd.rd_b ? zone_b : zone_a;

  zdlb_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_ZONES)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      build_half <= 1'b0;
    end else begin
      if (cmd.toggle_half) begin
        build_half <= !build_half;
      end
      if (cmd.clear_half) begin
        for (int z = 0; z < NUM_ZONES; z++) begin
          if (z >= int'(base) && z < int'(base) + HALF) begin
            vld[z] <= 1'b0;
          end
        end
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= zdlb_pkg::func_t'(func);
      addr_q <= gfx_address;
      x_q    <= x_position;
      y_q    <= y_position;
      wpal_q <= width_palette;
    end
    if (cmd.calc_div) begin
      quo_q <= y_quo;
      rem_q <= y_rem[7:0];
    end
    if (cmd.calc_zone) begin
      zone_a <= zone_mod;
      zone_b <= (zone_mod == ZW'(NUM_ZONES - 1)) ? '0 : zone_mod + 1'b1;
    end
    if (cmd.cap_a) begin
      fill_a <= vld[zone_a] ? rd_data : '0;
    end
    if (cmd.cap_b) begin
      fill_b <= vld[zone_b] ? rd_data : '0;
    end
  end

  // Entry bytes and write place for the current step
  assign sel_zone = (cmd.kind == zdlb_pkg::EMIT_B) ? zone_b : zone_a;
  assign sel_fill = (cmd.kind == zdlb_pkg::EMIT_B) ? fill_b : fill_a;
  assign hi_a     = addr_q[15:8] + rem_q;
  assign hi_sel   = (cmd.kind == zdlb_pkg::EMIT_B) ? hi_a - 8'(ZONE_LINES) : hi_a;
  assign idx      = cmd.step[2:0] - 3'd1;

  always_comb begin
    entry_byte = 8'd0;
    if (func_q == zdlb_pkg::FUNC_STRING) begin
      case (idx)
        3'd0:    entry_byte = addr_q[7:0];
        3'd1:    entry_byte = zdlb_pkg::INDIRECT_MODE;
        3'd2:    entry_byte = addr_q[15:8];
        3'd3:    entry_byte = wpal_q;
        3'd4:    entry_byte = x_q;
        default: entry_byte = 8'd0;
      endcase
    end else begin
      case (idx)
        3'd0:    entry_byte = addr_q[7:0];
        3'd1:    entry_byte = wpal_q;
        3'd2:    entry_byte = hi_sel;
        3'd3:    entry_byte = x_q;
        default: entry_byte = 8'd0;
      endcase
    end
  end

  always_comb begin
    case (cmd.kind)
      zdlb_pkg::EMIT_CLEAR: begin
        zone_ext = SUM_W'(base) + SUM_W'(cmd.step);
        off_ext  = SUM_W'(1);
      end
      zdlb_pkg::EMIT_A, zdlb_pkg::EMIT_B: begin
        zone_ext = SUM_W'(sel_zone);
        if (cmd.step == '0) begin
          off_ext = SUM_W'(sel_fill) + SUM_W'(len) + SUM_W'(1);
        end else begin
          off_ext = SUM_W'(sel_fill) + SUM_W'(cmd.step) - SUM_W'(1);
        end
      end
      default: begin
        zone_ext = '0;
        off_ext  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      write_valid  <= (cmd.kind != zdlb_pkg::EMIT_NONE);
      write_zone   <= zone_ext[4:0];
      write_offset <= off_ext[4:0];
      write_byte   <= ((cmd.kind == zdlb_pkg::EMIT_A || cmd.kind == zdlb_pkg::EMIT_B)
                       && cmd.step != '0) ? entry_byte : 8'd0;
      front_half   <= build_half;
      overflow     <= (cmd.kind == zdlb_pkg::EMIT_CLEAR) ? 1'b0 : ovf;
      last         <= cmd.last;
    end
  end

endmodule

// File: design/zdlb_ctrl.sv
// ---------------------------------------------------------------------------
// zdlb_ctrl
// Controller: sequences one request through setup, fill reads and writes.
// ---------------------------------------------------------------------------
`include "zone_display_list_builder_macros.svh"

module zdlb_ctrl #(
  parameter int NUM_ZONES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output zdlb_pkg::dp_cmd_t  cmd,
  input  zdlb_pkg::dp_stat_t stat
);

  localparam int STEP_W = zdlb_pkg::STEP_W;
  localparam int NCLR   = (NUM_ZONES / 2 < zdlb_pkg::MAX_RESULTS) ?
                          NUM_ZONES / 2 : zdlb_pkg::MAX_RESULTS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ZONE,
    ST_RD_A,
    ST_RD_B,
    ST_CAP,
    ST_CHK,
    ST_EM_CLR,
    ST_EM_A,
    ST_EM_B,
    ST_EM_NONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] alloc_last;
  logic              do_b;

  assign alloc_last = (stat.func == zdlb_pkg::FUNC_STRING) ? STEP_W'(5) : STEP_W'(4);
  assign do_b       = stat.split && stat.ok_b;

  always_comb begin
    cmd      = '0;
    cmd.kind = zdlb_pkg::EMIT_NONE;
    cmd.step = step;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_DIV:  cmd.calc_div = 1'b1;
      ST_ZONE: begin
        cmd.calc_zone   = 1'b1;
        cmd.clear_half  = (stat.func == zdlb_pkg::FUNC_CLEAR);
        cmd.toggle_half = (stat.func == zdlb_pkg::FUNC_SWAP);
      end
      ST_RD_A: cmd.rd_en = 1'b1;
      ST_RD_B: begin
        cmd.rd_en = 1'b1;
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
      end
      ST_CAP: cmd.cap_b = 1'b1;
      ST_EM_CLR: begin
        cmd.emit = stat.out_free;
        cmd.kind = zdlb_pkg::EMIT_CLEAR;
        cmd.last = (step == STEP_W'(NCLR - 1));
      end
      ST_EM_A: begin
        cmd.emit   = stat.out_free;
        cmd.kind   = zdlb_pkg::EMIT_A;
        cmd.commit = (step == alloc_last);
        cmd.last   = (step == alloc_last) && !do_b;
      end
      ST_EM_B: begin
        cmd.emit   = stat.out_free;
        cmd.kind   = zdlb_pkg::EMIT_B;
        cmd.commit = (step == alloc_last);
        cmd.last   = (step == alloc_last);
      end
      ST_EM_NONE: begin
        cmd.emit = stat.out_free;
        cmd.last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
      step     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_DIV;
            in_ready <= 1'b0;
          end
        end
        ST_DIV: state <= ST_ZONE;
        ST_ZONE: begin
          step <= '0;
          case (stat.func)
            zdlb_pkg::FUNC_CLEAR: state <= ST_EM_CLR;
            zdlb_pkg::FUNC_SWAP:  state <= ST_EM_NONE;
            default:              state <= ST_RD_A;
          endcase
        end
        ST_RD_A: state <= ST_RD_B;
        ST_RD_B: state <= ST_CAP;
        ST_CAP:  state <= ST_CHK;
        ST_CHK: begin
          // skip a refused allocation
          if (stat.ok_a) begin
            state <= ST_EM_A;
          end else if (do_b) begin
            state <= ST_EM_B;
          end else begin
            state <= ST_EM_NONE;
          end
        end
        ST_EM_CLR: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state    <= ST_IDLE;
              in_ready <= 1'b1;
              step     <= '0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_EM_A: begin
          if (cmd.emit) begin
            if (cmd.commit) begin
              step <= '0;
              if (do_b) begin
                state <= ST_EM_B;
              end else begin
                state    <= ST_IDLE;
                in_ready <= 1'b1;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_EM_B: begin
          if (cmd.emit) begin
            if (cmd.commit) begin
              step     <= '0;
              state    <= ST_IDLE;
              in_ready <= 1'b1;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_EM_NONE: begin
          if (cmd.emit) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `ZDLB_ASSERT(a_emit_room, cmd.emit, stat.out_free, "result issued into a busy output register")
  `ZDLB_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, !in_ready && state == ST_DIV, "request accepted without starting setup")
  `ZDLB_ASSERT(a_copy_fits, state == ST_EM_B, stat.split && stat.ok_b, "split copy written without room")
  `ZDLB_ASSERT(a_ready_idle, in_ready, state == ST_IDLE, "ready raised outside idle")

endmodule

// File: design/zone_display_list_builder.sv
// ---------------------------------------------------------------------------
// zone_display_list_builder
// Double-buffered zoned display list builder; every list byte write is
// delivered as one result.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    func, gfx_address, x_position,
//                                            y_position, width_palette
//   out      output     out_valid/out_ready  write_valid, write_zone,
//                                            write_offset, write_byte,
//                                            front_half, overflow, last
//
// Adds set up by zone divide, zone wrap, two fill RAM reads, capture and check;
// clear and swap by divide and wrap only. Then one result per cycle while the
// output is free; a new request is taken in the cycle after the final result.
// Synchronous reset clears the half select and every fill length valid bit.
// A stalled output holds the sequencer; the next request is taken while the
// final result of the previous one still waits.
// ---------------------------------------------------------------------------
module zone_display_list_builder #(
  parameter int NUM_ZONES  = 32,
  parameter int ZONE_BYTES = 32,
  parameter int ZONE_LINES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] gfx_address,
  input  logic [7:0]  x_position,
  input  logic [7:0]  y_position,
  input  logic [7:0]  width_palette,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [4:0]  write_zone,
  output logic [4:0]  write_offset,
  output logic [7:0]  write_byte,
  output logic        front_half,
  output logic        overflow,
  output logic        last
);

  zdlb_pkg::dp_cmd_t  cmd;
  zdlb_pkg::dp_stat_t stat;

  zdlb_ctrl #(
    .NUM_ZONES (NUM_ZONES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  zdlb_dp #(
    .NUM_ZONES  (NUM_ZONES),
    .ZONE_BYTES (ZONE_BYTES),
    .ZONE_LINES (ZONE_LINES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .gfx_address   (gfx_address),
    .x_position    (x_position),
    .y_position    (y_position),
    .width_palette (width_palette),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_valid   (write_valid),
    .write_zone    (write_zone),
    .write_offset  (write_offset),
    .write_byte    (write_byte),
    .front_half    (front_half),
    .overflow      (overflow),
    .last          (last)
  );

endmodule
